@@ hdl/pts_pkg.sv @@
`default_nettype none

package pts_pkg;

    localparam int COORD_W = 32;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int CLIP_W  = 49;
    localparam int NUM_W   = CLIP_W + 1;
    localparam int MAG_W   = CLIP_W;
    localparam int DIV_W   = CLIP_W;
    localparam int LO_W    = 32;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int LOP_W   = LO_W + DIM_W;
    localparam int HIP_W   = HI_W + DIM_W;
    localparam int MPROD_W = MAG_W + DIM_W;
    localparam int QUO_W   = 31;
    localparam int SAT_SH  = QUO_W - FRAC_W;
    localparam int RES_W   = QUO_W + 1;
    localparam int COEF_N  = 6;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [RES_W-1:0]   t_scr;
    typedef logic [REG_W-1:0]          t_reg;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [DIM_W-1:0]          t_dim;

    typedef struct packed {
        t_scr screen_x;
        t_scr screen_y;
        logic visible;
    } t_px;

    localparam t_idx REG_COEF_ROW0_XY  = 3'd0;
    localparam t_idx REG_COEF_ROW1_XY  = 3'd1;
    localparam t_idx REG_COEF_ROW2_XY  = 3'd2;
    localparam t_idx REG_COEF_ROW3_XY  = 3'd3;
    localparam t_idx REG_COEF_W_ROWS01 = 3'd4;
    localparam t_idx REG_COEF_W_ROWS23 = 3'd5;
    localparam t_idx REG_VIEW_WIDTH    = 3'd6;
    localparam t_idx REG_VIEW_HEIGHT   = 3'd7;

    localparam logic signed [CLIP_W-1:0] NEAR_LSB = 6;
    localparam t_scr SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam t_scr SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam t_dim DIM_ONE = 1;

endpackage

`default_nettype wire

@@ hdl/pts_if.sv @@
`default_nettype none

interface pts_in_if;
    import pts_pkg::*;
    logic   valid;
    logic   ready;
    t_coord world_x;
    t_coord world_y;
    t_coord world_z;
    modport source (output valid, output world_x, output world_y, output world_z,
                    input ready);
    modport sink (input valid, input world_x, input world_y, input world_z,
                  output ready);
endinterface

interface pts_out_if;
    import pts_pkg::*;
    logic valid;
    logic ready;
    t_scr screen_x;
    t_scr screen_y;
    logic visible;
    modport source (output valid, output screen_x, output screen_y, output visible,
                    input ready);
    modport sink (input valid, input screen_x, input screen_y, input visible,
                  output ready);
endinterface

interface pts_cfg_if;
    import pts_pkg::*;
    logic valid;
    logic ready;
    t_idx index;
    t_reg data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/point_to_screen_projection_top.sv @@
// Perspective point projection with viewport mapping.
// i_pt carries one world point (world_x, world_y, world_z, signed Q16.16) per beat;
// o_px returns one beat per point: screen_x, screen_y (signed Q16.16 pixels,
// y from the top, saturated) and visible. Points at or behind the near plane
// come out with visible low and both coordinates zero.
// i_cfg writes the matrix coefficients and the viewport size; ready is always
// high. Write it only while no points are in flight.
// Throughput: one point per cycle while the skid register is empty. The
// 31 compare-subtract stages of the pipelined divider, one quotient bit per
// stage, follow six multiply, add and divider-load stages.
// The divider has one lane for x and one for y.
// Reset clears all pipeline valid bits, the coefficients to zero and the
// viewport size to one pixel.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; i_pt.ready falls as soon as it does and
// the whole pipeline holds until the skid register drains.
`default_nettype none

module point_to_screen_projection_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pts_in_if.sink    i_pt,
    pts_out_if.source o_px,
    pts_cfg_if.sink   i_cfg
);
    import pts_pkg::*;

    t_reg r_coef [COEF_N];
    t_dim r_vw;
    t_dim r_vh;

    t_coord w_pt [3];
    t_coord w_m  [3][3];
    t_coord w_t  [3];
    t_dim   w_scale [2];
    logic   w_en;

    logic [QUO_W:0] r_dv_v;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    logic signed [PROD_W-1:0] r1_p [3][3];
    logic signed [CLIP_W-1:0] w_clip [3];
    logic signed [CLIP_W-1:0] r2_clip [3];

    logic signed [NUM_W-1:0] w_num [2];
    logic signed [NUM_W-1:0] w_abs [2];
    logic                    w_vis;
    logic [MAG_W-1:0]        r3_mag [2];
    logic                    r3_neg [2];
    logic [DIV_W-1:0]        r3_d;
    logic                    r3_vis;

    logic [LOP_W-1:0] r4_lo [2];
    logic [HIP_W-1:0] r4_hi [2];
    logic             r4_neg [2];
    logic [DIV_W-1:0] r4_d;
    logic             r4_vis;

    logic [MPROD_W-1:0] r5_m [2];
    logic               r5_neg [2];
    logic [DIV_W-1:0]   r5_d;
    logic               r5_vis;

    logic [DIV_W-1:0] r_dv_rem [QUO_W+1][2];
    logic [QUO_W-1:0] r_dv_low [QUO_W+1][2];
    logic [QUO_W-1:0] r_dv_q   [QUO_W+1][2];
    logic             r_dv_neg [QUO_W+1][2];
    logic             r_dv_sat [QUO_W+1][2];
    logic [DIV_W-1:0] r_dv_d   [QUO_W+1];
    logic             r_dv_vis [QUO_W+1];

    t_scr w_res [2];
    t_px  w_px;
    t_px  r_out;
    t_px  r_skid;
    logic r_out_v;
    logic r_skid_v;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_N; i++) begin
                r_coef[i] <= '0;
            end
            r_vw <= DIM_ONE;
            r_vh <= DIM_ONE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_COEF_ROW0_XY, REG_COEF_ROW1_XY, REG_COEF_ROW2_XY,
                REG_COEF_ROW3_XY, REG_COEF_W_ROWS01, REG_COEF_W_ROWS23: begin
                    r_coef[i_cfg.index] <= i_cfg.data;
                end
                REG_VIEW_WIDTH: begin
                    r_vw <= (i_cfg.data[DIM_W-1:0] == '0) ? DIM_ONE : i_cfg.data[DIM_W-1:0];
                end
                REG_VIEW_HEIGHT: begin
                    r_vh <= (i_cfg.data[DIM_W-1:0] == '0) ? DIM_ONE : i_cfg.data[DIM_W-1:0];
                end
            endcase
        end
    end

    assign w_pt[0] = i_pt.world_x;
    assign w_pt[1] = i_pt.world_y;
    assign w_pt[2] = i_pt.world_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_m[r][0] = r_coef[r][COORD_W-1:0];
            w_m[r][1] = r_coef[r][REG_W-1:COORD_W];
        end
        w_m[0][2] = r_coef[REG_COEF_W_ROWS01][COORD_W-1:0];
        w_m[1][2] = r_coef[REG_COEF_W_ROWS01][REG_W-1:COORD_W];
        w_m[2][2] = r_coef[REG_COEF_W_ROWS23][COORD_W-1:0];
        w_t[0]    = r_coef[REG_COEF_ROW3_XY][COORD_W-1:0];
        w_t[1]    = r_coef[REG_COEF_ROW3_XY][REG_W-1:COORD_W];
        w_t[2]    = r_coef[REG_COEF_W_ROWS23][REG_W-1:COORD_W];
    end

    assign w_scale[0] = r_vw;
    assign w_scale[1] = r_vh;

    assign w_en       = !r_skid_v;
    assign i_pt.ready = w_en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r_dv_v <= '0;
        end else if (w_en) begin
            r1_v   <= i_pt.valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r_dv_v <= {r_dv_v[QUO_W-1:0], r5_v};
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_p[r][c] <= w_pt[r] * w_m[r][c];
                end
            end
        end
    end

    // stage 2: floor each product to Q32.16 and sum the column
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_clip[c] = CLIP_W'($signed(r1_p[0][c][PROD_W-1:FRAC_W]))
                      + CLIP_W'($signed(r1_p[1][c][PROD_W-1:FRAC_W]))
                      + CLIP_W'($signed(r1_p[2][c][PROD_W-1:FRAC_W]))
                      + CLIP_W'(w_t[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r2_clip[c] <= w_clip[c];
            end
        end
    end

    // stage 3: numerators, sign and magnitude, divisor
    always_comb begin
        w_num[0] = NUM_W'(r2_clip[0]) + NUM_W'(r2_clip[2]);
        w_num[1] = NUM_W'(r2_clip[2]) - NUM_W'(r2_clip[1]);
        for (int k = 0; k < 2; k++) begin
            w_abs[k] = w_num[k][NUM_W-1] ? -w_num[k] : w_num[k];
        end
        w_vis = r2_clip[2] > NEAR_LSB;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 2; k++) begin
                r3_mag[k] <= w_abs[k][MAG_W-1:0];
                r3_neg[k] <= w_num[k][NUM_W-1];
            end
            r3_d   <= {r2_clip[2][DIV_W-2:0], 1'b0};
            r3_vis <= w_vis;
        end
    end

    // stage 4: scale partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 2; k++) begin
                r4_lo[k]  <= r3_mag[k][LO_W-1:0] * w_scale[k];
                r4_hi[k]  <= r3_mag[k][MAG_W-1:LO_W] * w_scale[k];
                r4_neg[k] <= r3_neg[k];
            end
            r4_d   <= r3_d;
            r4_vis <= r3_vis;
        end
    end

    // stage 5: combine partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 2; k++) begin
                r5_m[k]   <= MPROD_W'(r4_lo[k]) + (MPROD_W'(r4_hi[k]) << LO_W);
                r5_neg[k] <= r4_neg[k];
            end
            r5_d   <= r4_d;
            r5_vis <= r4_vis;
        end
    end

    // stage 6: saturation check and divider load
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 2; k++) begin
                r_dv_sat[0][k] <= r5_m[k] >= (MPROD_W'(r5_d) << SAT_SH);
                r_dv_rem[0][k] <= r5_m[k][SAT_SH +: DIV_W];
                r_dv_low[0][k] <= {r5_m[k][SAT_SH-1:0], FRAC_W'(0)};
                r_dv_q[0][k]   <= '0;
                r_dv_neg[0][k] <= r5_neg[k];
            end
            r_dv_d[0]   <= r5_d;
            r_dv_vis[0] <= r5_vis;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic [DIV_W:0] w_try [2];
        logic [DIV_W:0] w_dif [2];
        logic           w_ge  [2];

        always_comb begin
            for (int k = 0; k < 2; k++) begin
                w_try[k] = {r_dv_rem[j][k], r_dv_low[j][k][QUO_W-1]};
                w_dif[k] = w_try[k] - {1'b0, r_dv_d[j]};
                w_ge[k]  = w_try[k] >= {1'b0, r_dv_d[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 2; k++) begin
                    r_dv_rem[j+1][k] <= w_ge[k] ? w_dif[k][DIV_W-1:0] : w_try[k][DIV_W-1:0];
                    r_dv_low[j+1][k] <= {r_dv_low[j][k][QUO_W-2:0], 1'b0};
                    r_dv_q[j+1][k]   <= {r_dv_q[j][k][QUO_W-2:0], w_ge[k]};
                    r_dv_neg[j+1][k] <= r_dv_neg[j][k];
                    r_dv_sat[j+1][k] <= r_dv_sat[j][k];
                end
                r_dv_d[j+1]   <= r_dv_d[j];
                r_dv_vis[j+1] <= r_dv_vis[j];
            end
        end
    end

    // final rounding, sign and saturation
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            priority if (!r_dv_vis[QUO_W]) begin
                w_res[k] = '0;
            end else if (r_dv_sat[QUO_W][k]) begin
                w_res[k] = r_dv_neg[QUO_W][k] ? SAT_MIN : SAT_MAX;
            end else if (r_dv_neg[QUO_W][k]) begin
                w_res[k] = RES_W'(0) - ({1'b0, r_dv_q[QUO_W][k]}
                         + RES_W'(r_dv_rem[QUO_W][k] != '0));
            end else begin
                w_res[k] = {1'b0, r_dv_q[QUO_W][k]};
            end
        end
        w_px.screen_x = w_res[0];
        w_px.screen_y = w_res[1];
        w_px.visible  = r_dv_vis[QUO_W];
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_px.ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || o_px.ready) begin
            r_out_v <= r_dv_v[QUO_W];
        end else begin
            r_skid_v <= r_dv_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_px.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || o_px.ready) begin
            r_out <= w_px;
        end else begin
            r_skid <= w_px;
        end
    end

    assign o_px.valid    = r_out_v;
    assign o_px.screen_x = r_out.screen_x;
    assign o_px.screen_y = r_out.screen_y;
    assign o_px.visible  = r_out.visible;

endmodule

`default_nettype wire

@@ hdl/pts_checker.sv @@
`default_nettype none

module pts_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input pts_pkg::t_scr i_screen_x,
    input pts_pkg::t_scr i_screen_y,
    input logic          i_visible
);
    import pts_pkg::*;

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_visible |-> i_screen_x == '0 && i_screen_y == '0)
        else $error("hidden point with nonzero screen coordinates");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_screen_x)
            && $stable(i_screen_y) && $stable(i_visible))
        else $error("stalled output beat changed");

    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input held off with no output beat waiting");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("input beat dropped while held off");

endmodule

bind point_to_screen_projection_top pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_screen_x  (o_px.screen_x),
    .i_screen_y  (o_px.screen_y),
    .i_visible   (o_px.visible)
);

`default_nettype wire

@@ bench/tb_point_to_screen_projection_top.sv @@
module tb_point_to_screen_projection_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int LATENCY      = 37;
    localparam int STALL_LIMIT  = 2000;
    localparam int BATCH_POINTS = 200;
    localparam int BATCHES      = 7;

    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam t_coord UNIT      = 32'sh0001_0000;
    localparam t_coord HALF      = 32'sh0000_8000;

    typedef enum int {MAT_PERSPECTIVE, MAT_NOISE, MAT_EXTREME} t_mat_kind;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_world_pt;

    logic i_clk;
    logic i_rst_n;

    pts_in_if  pt_if ();
    pts_out_if px_if ();
    pts_cfg_if cfg_if ();

    t_reg      coef_regs [COEF_N];
    t_dim      view_w;
    t_dim      view_h;
    t_world_pt pending_pts [$];
    t_px       expected_px [$];
    t_world_pt cur_pt;
    int        src_gap_pct;
    int        sink_stall_pct;
    int        points_in;
    int        pixels_out;
    int        visible_out;
    int        reg_writes;
    int        settings_run;
    int        mismatches;
    int        stall_cycles;

    point_to_screen_projection_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_px    (px_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint coef_half(t_reg r, bit upper);
        logic signed [31:0] h;
        h = upper ? r[63:32] : r[31:0];
        return longint'(h);
    endfunction

    function automatic longint fix_mul(t_coord a, longint c);
        longint p;
        p = longint'(a) * c;
        return p >>> FRAC_W;
    endfunction

    function automatic t_scr to_pixels(longint n, t_dim scale, longint w);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        num = 128'(n);
        num = (num * $signed(128'(scale))) <<< FRAC_W;
        den = 128'(w);
        den = den <<< 1;
        q = num / den;
        if (num < 0 && q * den != num) begin
            q = q - 128'sd1;
        end
        if (q > 128'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (q < 128'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return q[31:0];
    endfunction

    function automatic t_px project_point(t_world_pt p);
        longint cx;
        longint cy;
        longint cw;
        t_px    r;
        cx = fix_mul(p.x, coef_half(coef_regs[REG_COEF_ROW0_XY], 1'b0))
           + fix_mul(p.y, coef_half(coef_regs[REG_COEF_ROW1_XY], 1'b0))
           + fix_mul(p.z, coef_half(coef_regs[REG_COEF_ROW2_XY], 1'b0))
           + coef_half(coef_regs[REG_COEF_ROW3_XY], 1'b0);
        cy = fix_mul(p.x, coef_half(coef_regs[REG_COEF_ROW0_XY], 1'b1))
           + fix_mul(p.y, coef_half(coef_regs[REG_COEF_ROW1_XY], 1'b1))
           + fix_mul(p.z, coef_half(coef_regs[REG_COEF_ROW2_XY], 1'b1))
           + coef_half(coef_regs[REG_COEF_ROW3_XY], 1'b1);
        cw = fix_mul(p.x, coef_half(coef_regs[REG_COEF_W_ROWS01], 1'b0))
           + fix_mul(p.y, coef_half(coef_regs[REG_COEF_W_ROWS01], 1'b1))
           + fix_mul(p.z, coef_half(coef_regs[REG_COEF_W_ROWS23], 1'b0))
           + coef_half(coef_regs[REG_COEF_W_ROWS23], 1'b1);
        r = '0;
        if (cw > longint'(NEAR_LSB)) begin
            r.screen_x = to_pixels(cx + cw, view_w, cw);
            r.screen_y = to_pixels(cw - cy, view_h, cw);
            r.visible  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rand_half(int lo, int hi);
        logic signed [31:0] h;
        h = $urandom;
        return h >>> $urandom_range(hi, lo);
    endfunction

    function automatic t_coord rand_coord();
        t_coord c;
        case ($urandom_range(7))
            0: c = $urandom;
            1: c = ($urandom_range(1) == 1) ? COORD_MAX : COORD_MIN;
            default: c = rand_half(8, 30);
        endcase
        return c;
    endfunction

    task automatic add_point(t_coord x, t_coord y, t_coord z);
        pending_pts.push_back('{x, y, z});
    endtask

    // hold until every point has gone in and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_pts.size() != 0 || pt_if.valid || expected_px.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(t_idx idx, t_reg data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_VIEW_WIDTH:  view_w = (data[DIM_W-1:0] == '0) ? DIM_ONE : data[DIM_W-1:0];
            REG_VIEW_HEIGHT: view_h = (data[DIM_W-1:0] == '0) ? DIM_ONE : data[DIM_W-1:0];
            default:         coef_regs[idx] = data;
        endcase
        reg_writes++;
    endtask

    task automatic write_matrix(input t_reg r [COEF_N], input t_dim w, input t_dim h);
        write_reg(REG_COEF_ROW0_XY, r[REG_COEF_ROW0_XY]);
        write_reg(REG_COEF_ROW1_XY, r[REG_COEF_ROW1_XY]);
        write_reg(REG_COEF_ROW2_XY, r[REG_COEF_ROW2_XY]);
        write_reg(REG_COEF_ROW3_XY, r[REG_COEF_ROW3_XY]);
        write_reg(REG_COEF_W_ROWS01, r[REG_COEF_W_ROWS01]);
        write_reg(REG_COEF_W_ROWS23, r[REG_COEF_W_ROWS23]);
        write_reg(REG_VIEW_WIDTH, t_reg'(w));
        write_reg(REG_VIEW_HEIGHT, t_reg'(h));
        cfg_if.valid <= 1'b0;
        settings_run++;
    endtask

    task automatic load_random_matrix(t_mat_kind kind);
        t_reg r [COEF_N];
        t_dim w;
        t_dim h;
        case (kind)
            MAT_PERSPECTIVE: begin
                r[REG_COEF_ROW0_XY]  = {rand_half(12, 20), rand_half(12, 20)};
                r[REG_COEF_ROW1_XY]  = {rand_half(12, 20), rand_half(12, 20)};
                r[REG_COEF_ROW2_XY]  = {rand_half(12, 20), rand_half(12, 20)};
                r[REG_COEF_ROW3_XY]  = {rand_half(8, 20), rand_half(8, 20)};
                r[REG_COEF_W_ROWS01] = {rand_half(20, 31), rand_half(20, 31)};
                r[REG_COEF_W_ROWS23] = {32'($urandom_range(1 << 22)),
                                        32'(UNIT + rand_half(18, 31))};
                w = t_dim'($urandom_range(4096, 1));
                h = t_dim'($urandom_range(4096, 1));
            end
            MAT_NOISE: begin
                foreach (r[i]) begin
                    r[i] = {$urandom, $urandom};
                end
                w = t_dim'($urandom_range(65535, 0));
                h = t_dim'($urandom_range(65535, 0));
            end
            default: begin
                foreach (r[i]) begin
                    case ($urandom_range(3))
                        0: r[i] = '1;
                        1: r[i] = {2{32'h7FFF_FFFF}};
                        2: r[i] = {2{32'h8000_0000}};
                        default: r[i] = '0;
                    endcase
                end
                w = ($urandom_range(1) == 1) ? 16'hFFFF : DIM_ONE;
                h = ($urandom_range(1) == 1) ? 16'hFFFF : DIM_ONE;
            end
        endcase
        write_matrix(r, w, h);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                expected_px.push_back(project_point(cur_pt));
                points_in++;
            end
            if (!pt_if.valid || pt_if.ready) begin
                if (pending_pts.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    cur_pt = pending_pts.pop_front();
                    pt_if.valid   <= 1'b1;
                    pt_if.world_x <= cur_pt.x;
                    pt_if.world_y <= cur_pt.y;
                    pt_if.world_z <= cur_pt.z;
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_px want;
        if (!i_rst_n) begin
            px_if.ready <= 1'b0;
        end else begin
            if (px_if.valid && px_if.ready) begin
                pixels_out++;
                if (expected_px.size() == 0) begin
                    $error("result beat with no point outstanding");
                    mismatches++;
                end else begin
                    want = expected_px.pop_front();
                    visible_out += int'(want.visible);
                    if (px_if.screen_x !== want.screen_x) begin
                        $error("screen_x: expected %0d, got %0d", want.screen_x, px_if.screen_x);
                        mismatches++;
                    end
                    if (px_if.screen_y !== want.screen_y) begin
                        $error("screen_y: expected %0d, got %0d", want.screen_y, px_if.screen_y);
                        mismatches++;
                    end
                    if (px_if.visible !== want.visible) begin
                        $error("visible: expected %0d, got %0d", want.visible, px_if.visible);
                        mismatches++;
                    end
                end
            end
            px_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((pt_if.valid && pt_if.ready) || (px_if.valid && px_if.ready)
                     || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_reg      mat [COEF_N];
        t_mat_kind plan [BATCHES];
        pt_if.valid   = 1'b0;
        pt_if.world_x = '0;
        pt_if.world_y = '0;
        pt_if.world_z = '0;
        px_if.ready   = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        foreach (coef_regs[i]) begin
            coef_regs[i] = '0;
        end
        view_w         = DIM_ONE;
        view_h         = DIM_ONE;
        points_in      = 0;
        pixels_out     = 0;
        visible_out    = 0;
        reg_writes     = 0;
        settings_run   = 0;
        mismatches     = 0;
        src_gap_pct    = 8;
        sink_stall_pct = 49;
        plan = '{MAT_PERSPECTIVE, MAT_NOISE, MAT_EXTREME, MAT_PERSPECTIVE,
                 MAT_EXTREME, MAT_NOISE, MAT_PERSPECTIVE};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero matrix out of reset: w is zero, so nothing is visible
        add_point('0, '0, '0);
        add_point(COORD_MAX, COORD_MIN, COORD_MAX);
        drain();

        // identity-like view: clip x = x, clip y = y, w = z
        mat = '{64'h0000_0000_0001_0000, 64'h0001_0000_0000_0000, '0, '0, '0,
                64'h0000_0000_0001_0000};
        write_matrix(mat, 16'd640, 16'd480);
        add_point('0, '0, UNIT);
        add_point(HALF, -HALF, UNIT);
        add_point('0, '0, 32'sd6);
        add_point('0, '0, 32'sd7);
        add_point('0, '0, -UNIT);
        add_point(COORD_MAX, COORD_MAX, UNIT);
        add_point(COORD_MIN, COORD_MIN, UNIT);
        add_point(COORD_MAX, COORD_MIN, COORD_MAX);
        add_point(COORD_MIN, COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN);
        add_point(32'sd1, -32'sd1, 32'sd7);
        drain();

        // a zero viewport size is held as one pixel
        write_reg(REG_VIEW_WIDTH, '0);
        write_reg(REG_VIEW_HEIGHT, '0);
        cfg_if.valid <= 1'b0;
        add_point(HALF, HALF, UNIT);
        add_point('0, '0, UNIT);
        drain();

        write_reg(REG_VIEW_WIDTH, 64'hFFFF);
        write_reg(REG_VIEW_HEIGHT, 64'hFFFF);
        cfg_if.valid <= 1'b0;
        add_point('0, '0, UNIT);
        add_point(COORD_MAX, COORD_MIN, UNIT);
        add_point(-HALF, HALF, UNIT);
        drain();

        for (int b = 0; b < BATCHES; b++) begin
            if (b < 2) begin
                src_gap_pct    = 8;
                sink_stall_pct = 49;
            end else if (b < 4) begin
                src_gap_pct    = 49;
                sink_stall_pct = 8;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            load_random_matrix(plan[b]);
            repeat (BATCH_POINTS / 2) add_point(rand_coord(), rand_coord(), rand_coord());
            drain();
            repeat (BATCH_POINTS / 2) add_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Projected %0d points into %0d result beats (%0d visible)",
                 points_in, pixels_out, visible_out);
        $display("over %0d matrix setups and %0d register writes; covered the near-plane",
                 settings_run, reg_writes);
        $display("cutoff, saturation both ways, zero and full viewports, stalls on both sides.");
        if (mismatches == 0 && expected_px.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
